[sv/qalt_pkg.sv]
// Package for the quote-aware line tokenizer: sizes, character codes,
// register indexes and the word types shared by all modules.
// Depends on nothing.
package qalt_pkg;

  localparam int unsigned MaxLine   = 4096;
  localparam int unsigned MaxTokens = 256;
  localparam int unsigned PosW      = 12;
  localparam int unsigned TokW      = 8;
  localparam int unsigned TokCntW   = 9;
  localparam int unsigned CharW     = 8;
  localparam int unsigned CfgW      = 23;
  localparam int unsigned ExitW     = 8;
  localparam int unsigned IdxW      = 1;
  localparam int unsigned DigN      = 7;
  localparam int unsigned DigIdxW   = 3;
  localparam int unsigned BcdW      = DigN * 4;
  localparam int unsigned IterW     = 5;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = 2;
  localparam int unsigned FifoCntW  = 3;

  localparam logic [IdxW-1:0] RegProcessId  = 1'b0;
  localparam logic [IdxW-1:0] RegExitStatus = 1'b1;

  localparam logic KindByte = 1'b0;
  localparam logic KindMark = 1'b1;

  localparam logic [CharW-1:0] ChNul      = 8'h00;
  localparam logic [CharW-1:0] ChTab      = 8'h09;
  localparam logic [CharW-1:0] ChNewline  = 8'h0A;
  localparam logic [CharW-1:0] ChSpace    = 8'h20;
  localparam logic [CharW-1:0] ChDquote   = 8'h22;
  localparam logic [CharW-1:0] ChDollar   = 8'h24;
  localparam logic [CharW-1:0] ChSquote   = 8'h27;
  localparam logic [CharW-1:0] ChZero     = 8'h30;
  localparam logic [CharW-1:0] ChQuestion = 8'h3F;

  typedef struct packed {
    logic [CharW-1:0] char_in;
    logic             line_end;
  } in_word_t;

  typedef struct packed {
    logic             kind;
    logic [CharW-1:0] out_byte;
    logic [PosW-1:0]  position;
    logic [TokW-1:0]  token_number;
    logic             overflow;
    logic             last;
  } out_word_t;

  typedef struct packed {
    logic             line_mark;
    logic             dollar_byte;
    logic             dec_en;
    logic             dec_pid;
    logic             mark_pre;
    logic             byte_en;
    logic [CharW-1:0] byte_val;
    logic             mark_post;
  } cmd_t;

  typedef struct packed {
    logic [BcdW-1:0] pid_bcd;
    logic [BcdW-1:0] exit_bcd;
  } bcd_t;

endpackage

[sv/qalt_bcd.sv]
// Configuration registers and their binary to BCD conversion.
// Converts each written register by shift-and-add-three, one bit a cycle.
// Depends on qalt_pkg.
module qalt_bcd (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [qalt_pkg::IdxW-1:0]    cfg_idx_i,
  input  logic [qalt_pkg::CfgW-1:0]    cfg_data_i,
  output logic                         busy_o,
  output qalt_pkg::bcd_t               bcd_o
);

  typedef enum logic {
    CS_IDLE,
    CS_RUN
  } conv_state_e;

  conv_state_e                    state_q;
  logic [qalt_pkg::CfgW-1:0]      pid_q;
  logic [qalt_pkg::ExitW-1:0]     exit_q;
  logic                           dirty_pid_q;
  logic                           dirty_exit_q;
  logic                           sel_pid_q;
  logic [qalt_pkg::CfgW-1:0]      bin_q;
  logic [qalt_pkg::CfgW-1:0]      bin_d;
  logic [qalt_pkg::BcdW-1:0]      acc_q;
  logic [qalt_pkg::BcdW-1:0]      acc_d;
  logic [qalt_pkg::BcdW-1:0]      acc_adj;
  logic [qalt_pkg::IterW-1:0]     cnt_q;
  logic [qalt_pkg::BcdW-1:0]      pid_bcd_q;
  logic [qalt_pkg::BcdW-1:0]      exit_bcd_q;

  always_comb begin
    for (int i = 0; i < qalt_pkg::DigN; i++) begin
      if (acc_q[4*i +: 4] >= 4'd5) begin
        acc_adj[4*i +: 4] = acc_q[4*i +: 4] + 4'd3;
      end else begin
        acc_adj[4*i +: 4] = acc_q[4*i +: 4];
      end
    end
    acc_d = {acc_adj[qalt_pkg::BcdW-2:0], bin_q[qalt_pkg::CfgW-1]};
    bin_d = {bin_q[qalt_pkg::CfgW-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= CS_IDLE;
      pid_q        <= qalt_pkg::CfgW'(1);
      exit_q       <= '0;
      dirty_pid_q  <= 1'b0;
      dirty_exit_q <= 1'b0;
      sel_pid_q    <= 1'b0;
      bin_q        <= '0;
      acc_q        <= '0;
      cnt_q        <= '0;
      pid_bcd_q    <= qalt_pkg::BcdW'(1);
      exit_bcd_q   <= '0;
    end else begin
      unique case (state_q)
        CS_IDLE: begin
          if (dirty_pid_q) begin
            sel_pid_q <= 1'b1;
            bin_q     <= pid_q;
            acc_q     <= '0;
            cnt_q     <= '0;
            state_q   <= CS_RUN;
          end else if (dirty_exit_q) begin
            sel_pid_q <= 1'b0;
            bin_q     <= qalt_pkg::CfgW'(exit_q);
            acc_q     <= '0;
            cnt_q     <= '0;
            state_q   <= CS_RUN;
          end
        end
        CS_RUN: begin
          acc_q <= acc_d;
          bin_q <= bin_d;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == qalt_pkg::IterW'(qalt_pkg::CfgW - 1)) begin
            state_q <= CS_IDLE;
            if (sel_pid_q) begin
              pid_bcd_q <= acc_d;
            end else begin
              exit_bcd_q <= acc_d;
            end
          end
        end
        default: state_q <= CS_IDLE;
      endcase
      if (cfg_we_i && cfg_idx_i == qalt_pkg::RegProcessId) begin
        pid_q       <= cfg_data_i;
        dirty_pid_q <= 1'b1;
      end else if (state_q == CS_IDLE && dirty_pid_q) begin
        dirty_pid_q <= 1'b0;
      end
      if (cfg_we_i && cfg_idx_i == qalt_pkg::RegExitStatus) begin
        exit_q       <= cfg_data_i[qalt_pkg::ExitW-1:0];
        dirty_exit_q <= 1'b1;
      end else if (state_q == CS_IDLE && !dirty_pid_q && dirty_exit_q) begin
        dirty_exit_q <= 1'b0;
      end
    end
  end

  assign busy_o         = (state_q != CS_IDLE) || dirty_pid_q || dirty_exit_q;
  assign bcd_o.pid_bcd  = pid_bcd_q;
  assign bcd_o.exit_bcd = exit_bcd_q;

endmodule

[sv/qalt_front.sv]
// Front end: accepts input words, tracks quoting mode, pending dollar and
// line start, and pushes a command for the back end for each word with work.
// Depends on qalt_pkg.
module qalt_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  qalt_pkg::in_word_t in_word_i,
  output logic               in_ready_o,
  input  logic               hold_i,
  input  logic               full_i,
  output logic               push_o,
  output qalt_pkg::cmd_t     cmd_o
);

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_BLANK,
    MODE_SQ,
    MODE_DQ
  } mode_e;

  mode_e                      mode_q;
  mode_e                      mode_d;
  mode_e                      mode;
  logic                       pend_q;
  logic                       pend_d;
  logic                       line_start_q;
  logic                       accept;
  logic                       handle;
  logic [qalt_pkg::CharW-1:0] c;
  qalt_pkg::cmd_t             cmd;

  assign in_ready_o = !full_i && !hold_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    c      = in_word_i.char_in;
    mode   = line_start_q ? MODE_NORMAL : mode_q;
    cmd    = '0;
    cmd.line_mark = line_start_q;
    mode_d = mode;
    pend_d = 1'b0;
    handle = 1'b1;
    if (pend_q && !line_start_q) begin
      if (c == qalt_pkg::ChDollar) begin
        cmd.dec_en  = 1'b1;
        cmd.dec_pid = 1'b1;
        handle      = 1'b0;
      end else if (c == qalt_pkg::ChQuestion) begin
        cmd.dec_en = 1'b1;
        handle     = 1'b0;
      end else begin
        cmd.dollar_byte = 1'b1;
      end
    end
    if (handle) begin
      if (c == qalt_pkg::ChSpace || c == qalt_pkg::ChTab) begin
        cmd.byte_en = 1'b1;
        if (mode == MODE_NORMAL) begin
          cmd.byte_val = qalt_pkg::ChNul;
          mode_d       = MODE_BLANK;
        end else begin
          cmd.byte_val = c;
        end
      end else if (c == qalt_pkg::ChDquote) begin
        if (mode == MODE_DQ) begin
          mode_d = MODE_NORMAL;
        end else if (mode == MODE_SQ) begin
          cmd.byte_en  = 1'b1;
          cmd.byte_val = c;
        end else begin
          cmd.mark_pre = (mode == MODE_BLANK);
          mode_d       = MODE_DQ;
        end
      end else if (c == qalt_pkg::ChSquote) begin
        if (mode == MODE_SQ) begin
          mode_d = MODE_NORMAL;
        end else if (mode == MODE_DQ) begin
          cmd.byte_en  = 1'b1;
          cmd.byte_val = c;
        end else begin
          cmd.mark_pre = (mode == MODE_BLANK);
          mode_d       = MODE_SQ;
        end
      end else if (c == qalt_pkg::ChDollar) begin
        if (mode == MODE_BLANK) begin
          cmd.mark_pre = 1'b1;
          mode_d       = MODE_NORMAL;
        end
        if (mode == MODE_SQ || in_word_i.line_end) begin
          cmd.byte_en  = 1'b1;
          cmd.byte_val = c;
        end else begin
          pend_d = 1'b1;
        end
      end else if (c == qalt_pkg::ChNewline) begin
        cmd.byte_en  = 1'b1;
        cmd.byte_val = qalt_pkg::ChNul;
      end else begin
        cmd.byte_en  = 1'b1;
        cmd.byte_val = c;
        if (mode == MODE_BLANK) begin
          cmd.mark_post = 1'b1;
          mode_d        = MODE_NORMAL;
        end
      end
    end
    if (in_word_i.line_end) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_NORMAL;
      pend_q       <= 1'b0;
      line_start_q <= 1'b1;
    end else if (accept) begin
      mode_q       <= mode_d;
      pend_q       <= pend_d;
      line_start_q <= in_word_i.line_end;
    end
  end

  assign cmd_o  = cmd;
  assign push_o = accept && (cmd.line_mark || cmd.dollar_byte || cmd.dec_en ||
                             cmd.mark_pre || cmd.byte_en || cmd.mark_post);

endmodule

[sv/qalt_fifo.sv]
// Short command queue between the front end and the back end.
// Depends on qalt_pkg.
module qalt_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  qalt_pkg::cmd_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output qalt_pkg::cmd_t rdata_o,
  output logic           empty_o
);

  qalt_pkg::cmd_t                 mem_q [qalt_pkg::FifoDepth];
  logic [qalt_pkg::FifoAw-1:0]    wr_q;
  logic [qalt_pkg::FifoAw-1:0]    rd_q;
  logic [qalt_pkg::FifoCntW-1:0]  cnt_q;
  logic                           do_push;
  logic                           do_pop;

  assign full_o  = (cnt_q == qalt_pkg::FifoCntW'(qalt_pkg::FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[sv/qalt_back.sv]
// Back end: carries out one command at a time, one result word a cycle unless
// the output stalls, keeping write position, token count and overflow, into
// an output register. Depends on qalt_pkg.
module qalt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  qalt_pkg::cmd_t      cmd_i,
  output logic                pop_o,
  input  qalt_pkg::bcd_t      bcd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output qalt_pkg::out_word_t out_word_o
);

  function automatic logic [qalt_pkg::DigIdxW-1:0] top_digit(
    logic [qalt_pkg::DigN-1:0][3:0] b
  );
    logic [qalt_pkg::DigIdxW-1:0] r;
    r = '0;
    for (int i = 0; i < qalt_pkg::DigN; i++) begin
      if (b[i] != 4'd0) begin
        r = qalt_pkg::DigIdxW'(i);
      end
    end
    return r;
  endfunction

  function automatic logic any_op(qalt_pkg::cmd_t k);
    return k.line_mark || k.dollar_byte || k.dec_en || k.mark_pre ||
           k.byte_en || k.mark_post;
  endfunction

  qalt_pkg::cmd_t                  ops_q;
  qalt_pkg::cmd_t                  ops_d;
  logic [qalt_pkg::DigIdxW-1:0]    dig_q;
  logic [qalt_pkg::DigIdxW-1:0]    dig_d;
  logic [qalt_pkg::PosW-1:0]       wp_q;
  logic [qalt_pkg::PosW-1:0]       wp_d;
  logic [qalt_pkg::PosW-1:0]       wp_b;
  logic [qalt_pkg::TokCntW-1:0]    tc_q;
  logic [qalt_pkg::TokCntW-1:0]    tc_d;
  logic [qalt_pkg::TokCntW-1:0]    tc_b;
  logic                            ovf_q;
  logic                            ovf_d;
  logic                            ovf_b;
  logic [qalt_pkg::PosW-1:0]       lbp_q;
  logic [qalt_pkg::PosW-1:0]       lbp_d;
  logic                            out_valid_q;
  qalt_pkg::out_word_t             out_q;
  qalt_pkg::out_word_t             res;
  logic                            busy;
  logic                            adv;
  logic                            emit;
  logic                            is_mark;
  logic [qalt_pkg::CharW-1:0]      bval;
  logic [qalt_pkg::PosW-1:0]       mpos;
  logic [qalt_pkg::DigN-1:0][3:0]  cur_bcd;
  logic [qalt_pkg::DigN-1:0][3:0]  new_bcd;

  assign busy  = any_op(ops_q);
  assign adv   = !out_valid_q || out_ready_i;
  assign emit  = busy && adv;
  assign pop_o = !busy && !empty_i;

  assign cur_bcd = ops_q.dec_pid ? bcd_i.pid_bcd : bcd_i.exit_bcd;
  assign new_bcd = cmd_i.dec_pid ? bcd_i.pid_bcd : bcd_i.exit_bcd;

  always_comb begin
    ops_d   = ops_q;
    dig_d   = dig_q;
    lbp_d   = lbp_q;
    is_mark = 1'b0;
    bval    = qalt_pkg::ChNul;
    mpos    = wp_q;
    wp_b    = wp_q;
    tc_b    = tc_q;
    ovf_b   = ovf_q;
    if (ops_q.line_mark) begin
      ops_d.line_mark = 1'b0;
      is_mark         = 1'b1;
      wp_b            = '0;
      tc_b            = '0;
      ovf_b           = 1'b0;
      mpos            = '0;
    end else if (ops_q.dollar_byte) begin
      ops_d.dollar_byte = 1'b0;
      bval              = qalt_pkg::ChDollar;
    end else if (ops_q.dec_en) begin
      bval = qalt_pkg::ChZero + {4'd0, cur_bcd[dig_q]};
      if (dig_q == '0) begin
        ops_d.dec_en = 1'b0;
      end else begin
        dig_d = dig_q - 1'b1;
      end
    end else if (ops_q.mark_pre) begin
      ops_d.mark_pre = 1'b0;
      is_mark        = 1'b1;
    end else if (ops_q.byte_en) begin
      ops_d.byte_en = 1'b0;
      bval          = ops_q.byte_val;
    end else begin
      ops_d.mark_post = 1'b0;
      is_mark         = 1'b1;
      mpos            = lbp_q;
    end

    wp_d  = wp_b;
    tc_d  = tc_b;
    ovf_d = ovf_b;
    res   = '0;
    if (is_mark) begin
      res.kind     = qalt_pkg::KindMark;
      res.position = mpos;
      if (tc_b < qalt_pkg::TokCntW'(qalt_pkg::MaxTokens)) begin
        res.token_number = tc_b[qalt_pkg::TokW-1:0];
        tc_d             = tc_b + 1'b1;
      end else begin
        res.token_number = qalt_pkg::TokW'(qalt_pkg::MaxTokens - 1);
        ovf_d            = 1'b1;
      end
    end else begin
      res.kind     = qalt_pkg::KindByte;
      res.out_byte = bval;
      res.position = wp_b;
      lbp_d        = wp_b;
      if (wp_b < qalt_pkg::PosW'(qalt_pkg::MaxLine - 1)) begin
        wp_d = wp_b + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end
    res.overflow = ovf_d;
    res.last     = !any_op(ops_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ops_q       <= '0;
      dig_q       <= '0;
      wp_q        <= '0;
      tc_q        <= '0;
      ovf_q       <= 1'b0;
      lbp_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        ops_q <= cmd_i;
        dig_q <= top_digit(new_bcd);
      end else if (emit) begin
        ops_q <= ops_d;
        dig_q <= dig_d;
        wp_q  <= wp_d;
        tc_q  <= tc_d;
        ovf_q <= ovf_d;
        lbp_q <= lbp_d;
      end
      if (adv) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

[sv/quote_aware_line_tokenizer_unit.sv]
// Top level of the quote-aware line tokenizer: front end, command queue,
// back end and configuration converter.
// Depends on qalt_pkg, qalt_bcd, qalt_front, qalt_fifo and qalt_back.
//
//   Channel  Signals                          Word
//   input    in_valid_i / in_ready_o          in_word_i  (char_in, line_end)
//   output   out_valid_o / out_ready_i        out_word_o (kind .. last)
//   config   cfg_we_i, cfg_idx_i, cfg_data_i  one register per write
//
// The front end takes one input word a cycle while the queue has room and no
// register write or conversion is pending; a full queue of four commands holds
// off input. The back end loads a command, then sends one result word a cycle
// while the output is not stalled; a dollar pair gives one result per digit.
// A register write holds off input until its conversion is done.
// Reset returns both registers to their reset values and empties the queue.
module quote_aware_line_tokenizer_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  qalt_pkg::in_word_t        in_word_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output qalt_pkg::out_word_t       out_word_o,
  input  logic                      cfg_we_i,
  input  logic [qalt_pkg::IdxW-1:0] cfg_idx_i,
  input  logic [qalt_pkg::CfgW-1:0] cfg_data_i
);

  logic           conv_busy;
  qalt_pkg::bcd_t bcd;
  logic           push;
  logic           full;
  logic           pop;
  logic           empty;
  qalt_pkg::cmd_t cmd_wr;
  qalt_pkg::cmd_t cmd_rd;

  qalt_bcd u_bcd (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .busy_o     (conv_busy),
    .bcd_o      (bcd)
  );

  qalt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .in_ready_o (in_ready_o),
    .hold_i     (conv_busy || cfg_we_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (cmd_wr)
  );

  qalt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_wr),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (cmd_rd),
    .empty_o (empty)
  );

  qalt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .cmd_i       (cmd_rd),
    .pop_o       (pop),
    .bcd_i       (bcd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
